// ===== sv/tcd_pkg.sv =====
// Shared types, constants and codes for the text cursor command generator.
package tcd_pkg;

  // Cell geometry and screen limits
  localparam int CELL_HEIGHT = 16;
  localparam int CELL_WIDTH  = 8;
  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 128;
  localparam int TAB_STOP    = 8;

  // Command queue depth between front and back (2..16)
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int PX_W    = 11;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 7;
  localparam int COLS_W  = 9;
  localparam int ROWS_W  = 8;
  localparam int COLOR_W = 24;
  localparam int CHAR_W  = 8;

  // Output payload layout in tdata, lowest bit first
  localparam int TD_TOP    = 0;
  localparam int TD_LEFT   = TD_TOP + PX_W;
  localparam int TD_BOTTOM = TD_LEFT + PX_W;
  localparam int TD_RIGHT  = TD_BOTTOM + PX_W;
  localparam int TD_GLYPH  = TD_RIGHT + PX_W;
  localparam int TD_COLOR  = TD_GLYPH + CHAR_W;
  localparam int TD_USED   = TD_COLOR + COLOR_W;
  localparam int TD_W      = ((TD_USED + 7) / 8) * 8;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;

  // Register map
  localparam int CFG_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_ENABLED = 2'd0,
    REG_COLS    = 2'd1,
    REG_ROWS    = 2'd2,
    REG_FG      = 2'd3
  } reg_idx_t;

  localparam logic [COLS_W-1:0]  COLS_RST = 9'd80;
  localparam logic [ROWS_W-1:0]  ROWS_RST = 8'd25;
  localparam logic [COLOR_W-1:0] FG_RST   = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,
    OP_GLYPH  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // What follows the optional cell fill and glyph of a job
  typedef enum logic [1:0] {
    TAIL_NONE    = 2'd0,
    TAIL_SCROLL  = 2'd1,
    TAIL_ROWFILL = 2'd2,
    TAIL_CLEAR   = 2'd3
  } tail_t;

  typedef enum logic [1:0] {
    PH_FILL  = 2'd0,
    PH_GLYPH = 2'd1,
    PH_TAIL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic               enabled;
    logic [COLS_W-1:0]  cols;
    logic [ROWS_W-1:0]  rows;
    logic [COLOR_W-1:0] fg;
  } cfg_t;

  typedef struct packed {
    logic               cell_en;
    tail_t              tail;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   fill_row;
    logic [COLS_W-1:0]  fill_cols;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] color;
  } job_t;

  typedef struct packed {
    op_t                op;
    logic [PX_W-1:0]    top;
    logic [PX_W-1:0]    left;
    logic [PX_W-1:0]    bottom;
    logic [PX_W-1:0]    right;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] color;
    logic               last;
  } cmd_t;

endpackage

// ===== sv/text_cursor_display_commands_top.sv =====
// Top level of the text cursor command generator: register file, front, queue, back.
//
//   Channel  Direction  Handshake                    Payload
//   in_      slave      in_tvalid / in_tready        tuser = command, tdata = char_code
//   out_     master     out_tvalid / out_tready      tuser = op, tdata = coords/glyph/color,
//                                                    tlast = last
//   cfg_     APB        psel / penable / pready      4 registers at byte address 4*i
//
// An item is taken when the job queue has room; the sequencer issues one display command
// per cycle while out_tready allows, so a printable character yields a fill, a glyph and an
// optional scroll, and any other item at most one. The single output register sets that rate.
// The job queue lets the next items be accepted while commands wait on out_tready.
// Reset is synchronous: it clears the cursor, the queue and the output register.
module text_cursor_display_commands_top #(
  parameter int QUEUE_DEPTH = tcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tcd_pkg::CHAR_W-1:0]     in_tdata,   // [7:0] char_code
  input  logic                           in_tuser,   // [0] command
  // display command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tcd_pkg::TD_W-1:0]       out_tdata,  // [10:0] top_px, [21:11] left_px,
                                                     // [32:22] bottom_px, [43:33] right_px,
                                                     // [51:44] glyph, [75:52] color, zero above
  output logic [1:0]                     out_tuser,  // [1:0] op
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tcd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import tcd_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     q_full, q_push, q_pop, q_valid;
  job_t     push_job, pop_job;
  cmd_t     out_cmd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLED: cfg_nxt.enabled = cfg_pwdata[0];
        REG_COLS:    cfg_nxt.cols    = cfg_pwdata[COLS_W-1:0];
        REG_ROWS:    cfg_nxt.rows    = cfg_pwdata[ROWS_W-1:0];
        REG_FG:      cfg_nxt.fg      = cfg_pwdata[COLOR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLED: cfg_prdata = 32'(cfg_r.enabled);
      REG_COLS:    cfg_prdata = 32'(cfg_r.cols);
      REG_ROWS:    cfg_prdata = 32'(cfg_r.rows);
      REG_FG:      cfg_prdata = 32'(cfg_r.fg);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled <= 1'b0;
      cfg_r.cols    <= COLS_RST;
      cfg_r.rows    <= ROWS_RST;
      cfg_r.fg      <= FG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (q_push),
    .job       (push_job)
  );

  tcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_job)
  );

  tcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_cmd    (out_cmd)
  );

  assign out_tdata = {(TD_W - TD_USED)'(0), out_cmd.color, out_cmd.glyph,
                      out_cmd.right, out_cmd.bottom, out_cmd.left, out_cmd.top};
  assign out_tuser = out_cmd.op;
  assign out_tlast = out_cmd.last;

endmodule

// ===== sv/tcd_front.sv =====
// Front end: accepts items, tracks the cursor and queues drawing jobs.
module tcd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcd_pkg::cfg_t               cfg,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,
  input  logic [tcd_pkg::CHAR_W-1:0]  in_tdata,
  input  logic                        q_full,
  output logic                        push,
  output tcd_pkg::job_t               job
);
  import tcd_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              accept;
  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic [COL_W-1:0]  col_s;
  logic [ROW_W-1:0]  row_s;
  logic [ROW_W-1:0]  row_inc;
  logic              at_bottom;
  logic [COLS_W-1:0] tab_nc;
  logic [COLS_W-1:0] col_inc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  // Clamp dimensions, then pull the cursor back inside the screen
  always_comb begin
    if (cfg.cols == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cfg.cols > COLS_W'(MAX_COLS)) begin
      cols_eff = COLS_W'(MAX_COLS);
    end else begin
      cols_eff = cfg.cols;
    end
    if (cfg.rows == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (cfg.rows > ROWS_W'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = cfg.rows;
    end
  end

  assign col_s     = ({1'b0, col_r} >= cols_eff) ? COL_W'(cols_eff - 1'b1) : col_r;
  assign row_s     = ({1'b0, row_r} >= rows_eff) ? ROW_W'(rows_eff - 1'b1) : row_r;
  assign at_bottom = ({1'b0, row_s} + ROWS_W'(1)) >= rows_eff;
  assign row_inc   = row_s + ROW_W'(1);
  assign tab_nc    = (COLS_W'(col_s) + COLS_W'(TAB_STOP)) & ~COLS_W'(TAB_STOP - 1);
  assign col_inc   = COLS_W'(col_s) + COLS_W'(1);

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    push          = 1'b0;
    job.cell_en   = 1'b0;
    job.tail      = TAIL_NONE;
    job.cell_row  = row_s;
    job.cell_col  = col_s;
    job.fill_row  = row_inc;
    job.fill_cols = cols_eff;
    job.glyph     = in_tdata;
    job.color     = cfg.fg;
    if (accept && cfg.enabled) begin
      if (in_tuser) begin
        col_nxt  = '0;
        row_nxt  = '0;
        push     = 1'b1;
        job.tail = TAIL_CLEAR;
      end else begin
        unique case (in_tdata)
          CH_NUL: begin
          end
          CH_NEWLINE: begin
            col_nxt = '0;
            push    = 1'b1;
            if (at_bottom) begin
              row_nxt  = row_s;
              job.tail = TAIL_SCROLL;
            end else begin
              row_nxt  = row_inc;
              job.tail = TAIL_ROWFILL;
            end
          end
          CH_CR: begin
            col_nxt = '0;
            row_nxt = row_s;
          end
          CH_TAB: begin
            if (tab_nc >= cols_eff) begin
              col_nxt = '0;
              if (at_bottom) begin
                row_nxt  = row_s;
                push     = 1'b1;
                job.tail = TAIL_SCROLL;
              end else begin
                row_nxt = row_inc;
              end
            end else begin
              col_nxt = tab_nc[COL_W-1:0];
              row_nxt = row_s;
            end
          end
          default: begin
            push        = 1'b1;
            job.cell_en = 1'b1;
            if (col_inc >= cols_eff) begin
              col_nxt = '0;
              if (at_bottom) begin
                row_nxt  = row_s;
                job.tail = TAIL_SCROLL;
              end else begin
                row_nxt = row_inc;
              end
            end else begin
              col_nxt = col_inc[COL_W-1:0];
              row_nxt = row_s;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== sv/tcd_queue.sv =====
// Short job queue between the front end and the command sequencer.
module tcd_queue #(
  parameter int DEPTH = tcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcd_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output tcd_pkg::job_t pop_data
);
  import tcd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/tcd_back.sv =====
// Back end: expands each job into display commands behind an output register.
module tcd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  tcd_pkg::job_t             q_job,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output tcd_pkg::cmd_t             out_cmd
);
  import tcd_pkg::*;

  localparam logic [PX_W-1:0] CH_PX = PX_W'(CELL_HEIGHT);
  localparam logic [PX_W-1:0] CW_PX = PX_W'(CELL_WIDTH);

  job_t            job_r, job_nxt;
  logic            job_valid_r, job_valid_nxt;
  phase_t          phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;
  cmd_t            out_cmd_r, out_cmd_nxt;
  cmd_t            cmd;
  logic            slot_free;
  logic            emit;
  logic            load;
  logic [PX_W-1:0] cell_top, cell_left, fill_top, fill_right;

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = job_valid_r && slot_free;
  assign load      = q_valid && (!job_valid_r || (emit && cmd.last));
  assign q_pop     = load;

  // Coordinates wrap at 11 bits; every resulting edge fits in 11 bits
  assign cell_top   = PX_W'(job_r.cell_row) * CH_PX;
  assign cell_left  = PX_W'(job_r.cell_col) * CW_PX;
  assign fill_top   = PX_W'(job_r.fill_row) * CH_PX;
  assign fill_right = PX_W'(job_r.fill_cols) * CW_PX - PX_W'(1);

  // Next phase, job and job valid
  always_comb begin
    phase_nxt     = phase_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    if (load) begin
      job_nxt       = q_job;
      job_valid_nxt = 1'b1;
      phase_nxt     = q_job.cell_en ? PH_FILL : PH_TAIL;
    end else if (emit) begin
      if (cmd.last) begin
        job_valid_nxt = 1'b0;
      end
      unique case (phase_r)
        PH_FILL:  phase_nxt = PH_GLYPH;
        PH_GLYPH: phase_nxt = PH_TAIL;
        PH_TAIL:  phase_nxt = PH_TAIL;
        default:  phase_nxt = PH_TAIL;
      endcase
    end
  end

  // Command for the current phase
  always_comb begin
    cmd = '0;
    unique case (phase_r)
      PH_FILL: begin
        cmd.op     = OP_FILL;
        cmd.top    = cell_top;
        cmd.left   = cell_left;
        cmd.bottom = cell_top + CH_PX - PX_W'(1);
        cmd.right  = cell_left + CW_PX - PX_W'(1);
      end
      PH_GLYPH: begin
        cmd.op    = OP_GLYPH;
        cmd.top   = cell_top;
        cmd.left  = cell_left;
        cmd.glyph = job_r.glyph;
        cmd.color = job_r.color;
        cmd.last  = (job_r.tail == TAIL_NONE);
      end
      PH_TAIL: begin
        cmd.last = 1'b1;
        unique case (job_r.tail)
          TAIL_SCROLL: cmd.op = OP_SCROLL;
          TAIL_CLEAR:  cmd.op = OP_CLEAR;
          TAIL_ROWFILL: begin
            cmd.op     = OP_FILL;
            cmd.top    = fill_top;
            cmd.bottom = fill_top + CH_PX - PX_W'(1);
            cmd.right  = fill_right;
          end
          TAIL_NONE: cmd.op = OP_FILL;
        endcase
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    if (slot_free) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_cmd_nxt = cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      phase_r     <= PH_TAIL;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    out_cmd_r <= out_cmd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_cmd    = out_cmd_r;

endmodule

// ===== sv/tcd_checker.sv =====
// Port-level checks on the display command stream, bound to the top level.
module tcd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [tcd_pkg::TD_W-1:0] out_tdata,
  input logic [1:0]               out_tuser,
  input logic                     out_tlast
);
  import tcd_pkg::*;

  // A stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled display command changed");

  // Scroll and clear carry no coordinates, glyph or color
  a_bare_ops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == OP_SCROLL || out_tuser == OP_CLEAR) |-> out_tdata == '0)
    else $error("scroll or clear with nonzero payload");

  // Clear comes alone and so ends its item
  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OP_CLEAR |-> out_tlast)
    else $error("clear screen without tlast");

  // Glyph commands have no bottom or right edge
  a_glyph_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OP_GLYPH |-> out_tdata[TD_GLYPH-1:TD_BOTTOM] == '0)
    else $error("glyph command with rectangle edges");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind text_cursor_display_commands_top tcd_checker u_tcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the text cursor command generator: predicts display commands.
module tb_top;
  import tcd_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT     = 3000000;
  localparam int IDLE_PCT      = 38;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [TD_W-1:0]       out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Predictor state: register copies and cursor
  logic               cfg_en   = 1'b0;
  logic [COLS_W-1:0]  cfg_cols = COLS_RST;
  logic [ROWS_W-1:0]  cfg_rows = ROWS_RST;
  logic [COLOR_W-1:0] cfg_fg   = FG_RST;
  logic [COL_W-1:0]   cur_col  = '0;
  logic [ROW_W-1:0]   cur_row  = '0;

  cmd_t pending_cmds[$];
  int   mismatch_count = 0;
  bit   steady_flow    = 1'b0;

  text_cursor_display_commands_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [7:0] char_code
    .in_tuser    (in_tuser),    // [0] command
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [10:0] top, [21:11] left, [32:22] bottom, [43:33] right,
                                // [51:44] glyph, [75:52] color
    .out_tuser   (out_tuser),   // [1:0] op
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic void emit_cmd(op_t op, int top, int left, int bottom, int right,
                                   logic [CHAR_W-1:0] glyph, logic [COLOR_W-1:0] color);
    cmd_t c;
    c.op     = op;
    c.top    = top[PX_W-1:0];
    c.left   = left[PX_W-1:0];
    c.bottom = bottom[PX_W-1:0];
    c.right  = right[PX_W-1:0];
    c.glyph  = glyph;
    c.color  = color;
    c.last   = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  // Go to column 0 of the next row; scroll instead when already on the last row
  function automatic void next_line(int rows, int cols, bit clear_row);
    int row_top;
    cur_col = '0;
    if (int'(cur_row) + 1 >= rows) begin
      emit_cmd(OP_SCROLL, 0, 0, 0, 0, '0, '0);
      return;
    end
    cur_row = cur_row + 1'b1;
    row_top = int'(cur_row) * CELL_HEIGHT;
    if (clear_row)
      emit_cmd(OP_FILL, row_top, 0, row_top + CELL_HEIGHT - 1, CELL_WIDTH * cols - 1, '0, '0);
  endfunction

  function automatic void predict_commands(logic is_reset, logic [CHAR_W-1:0] code);
    int cols, rows, nxt, top, left, base;
    base = pending_cmds.size();
    if (!cfg_en) return;
    if (is_reset) begin
      cur_col = '0;
      cur_row = '0;
      emit_cmd(OP_CLEAR, 0, 0, 0, 0, '0, '0);
    end else if (code != CH_NUL) begin
      cols = (cfg_cols == 0) ? 1 : (cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
      rows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      // clamp a cursor left outside a shrunken screen
      if (cur_col >= cols) cur_col = COL_W'(cols - 1);
      if (cur_row >= rows) cur_row = ROW_W'(rows - 1);
      case (code)
        CH_NEWLINE: next_line(rows, cols, 1'b1);
        CH_CR:      cur_col = '0;
        CH_TAB: begin
          nxt = (int'(cur_col) + TAB_STOP) & ~(TAB_STOP - 1);
          if (nxt >= cols) next_line(rows, cols, 1'b0);
          else cur_col = COL_W'(nxt);
        end
        default: begin
          top  = int'(cur_row) * CELL_HEIGHT;
          left = int'(cur_col) * CELL_WIDTH;
          emit_cmd(OP_FILL, top, left, top + CELL_HEIGHT - 1, left + CELL_WIDTH - 1, '0, '0);
          emit_cmd(OP_GLYPH, top, left, 0, 0, code, cfg_fg);
          if (int'(cur_col) + 1 >= cols) next_line(rows, cols, 1'b0);
          else cur_col = cur_col + 1'b1;
        end
      endcase
    end
    if (pending_cmds.size() > base) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Check every accepted command and randomize backpressure
  always @(posedge clk) begin : check_commands
    cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: no command expected, got op %0d tdata %h last %0d",
                 $time, out_tuser, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("op", int'(want.op), int'(out_tuser));
        check_field("top_px", int'(want.top), int'(out_tdata[TD_TOP +: PX_W]));
        check_field("left_px", int'(want.left), int'(out_tdata[TD_LEFT +: PX_W]));
        check_field("bottom_px", int'(want.bottom), int'(out_tdata[TD_BOTTOM +: PX_W]));
        check_field("right_px", int'(want.right), int'(out_tdata[TD_RIGHT +: PX_W]));
        check_field("glyph", int'(want.glyph), int'(out_tdata[TD_GLYPH +: CHAR_W]));
        check_field("color", int'(want.color), int'(out_tdata[TD_COLOR +: COLOR_W]));
        check_field("last", int'(want.last), int'(out_tlast));
      end
    end
    out_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Leaves tvalid high so back-to-back items need no second assignment in one step
  task automatic send_item(logic is_reset, logic [CHAR_W-1:0] code);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_reset;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    predict_commands(is_reset, code);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_cmds.size() != 0) begin
      $display("%0t: op %0d expected, got nothing (%0d commands missing)",
               $time, pending_cmds[0].op, pending_cmds.size());
      mismatch_count++;
      pending_cmds.delete();
    end
    // items with no command may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ENABLED: cfg_en   = value[0];
      REG_COLS:    cfg_cols = value[COLS_W-1:0];
      REG_ROWS:    cfg_rows = value[ROWS_W-1:0];
      REG_FG:      cfg_fg   = value[COLOR_W-1:0];
    endcase
  endtask

  task automatic set_screen(logic en, int cols, int rows, logic [COLOR_W-1:0] fg);
    drain_results();
    write_reg(REG_ENABLED, {31'd0, en});
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_FG, {8'd0, fg});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_printable();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (c == CH_NUL || c == CH_TAB || c == CH_NEWLINE || c == CH_CR);
    return c;
  endfunction

  task automatic test_disabled_after_reset();
    send_item(1'b0, 8'h41);
    send_item(1'b0, CH_NEWLINE);
    send_item(1'b1, 8'h00);
    send_item(1'b0, CH_TAB);
    drain_results();
  endtask

  task automatic test_control_chars();
    set_screen(1'b1, 10, 3, 24'h123456);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h41);
    send_item(1'b0, CH_TAB);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h80);        // last column: wraps to the next row
    send_item(1'b0, CH_NEWLINE);   // clears the bottom row
    send_item(1'b0, CH_CR);
    send_item(1'b0, CH_TAB);
    send_item(1'b0, CH_TAB);       // past the width on the last row: scroll
    send_item(1'b0, CH_NEWLINE);   // scroll
    send_item(1'b0, CH_NUL);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h55);
    send_item(1'b0, 8'hAA);
    send_item(1'b0, CH_NEWLINE);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h5A);
  endtask

  task automatic test_one_cell_screen();
    // zero dimensions count as one cell
    set_screen(1'b1, 0, 0, 24'hFFFFFF);
    send_item(1'b0, 8'h78);
    send_item(1'b0, CH_NEWLINE);
    send_item(1'b0, CH_TAB);
    send_item(1'b0, CH_CR);
    send_item(1'b0, 8'h79);
  endtask

  task automatic walk_to_last_column();
    repeat (31) send_item(1'b0, CH_TAB);
    repeat (8) send_item(1'b0, pick_printable());
  endtask

  task automatic test_far_corner();
    // oversized dimensions clamp to the largest screen
    set_screen(1'b1, 9'h1FF, 8'hFF, 24'h000000);
    send_item(1'b1, 8'h00);
    walk_to_last_column();
    repeat (126) send_item(1'b0, CH_NEWLINE);
    walk_to_last_column();
    send_item(1'b0, CH_TAB);
    send_item(1'b0, CH_TAB);
  endtask

  task automatic test_cursor_clamp();
    set_screen(1'b1, 10, 3, 24'hA5A5A5);
    send_item(1'b0, pick_printable());
    send_item(1'b0, pick_printable());
    set_screen(1'b1, 1, 2, 24'h5A5A5A);
    send_item(1'b0, CH_TAB);
    send_item(1'b0, pick_printable());
  endtask

  task automatic test_random_text();
    logic              is_reset;
    logic [CHAR_W-1:0] code;
    int                pick;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 5)
        set_screen(1'b1, $urandom_range(0, 511), $urandom_range(0, 255), COLOR_W'($urandom));
      else
        set_screen(phase != 3, $urandom_range(1, 40), $urandom_range(0, 6),
                   COLOR_W'($urandom));
      steady_flow = (phase == 2);
      // the stretch without idling runs longest
      repeat ((phase == 2) ? 30 : 8) begin
        pick     = $urandom_range(99);
        is_reset = (pick < 4);
        code     = CHAR_W'($urandom_range(255));
        if (pick >= 4) begin
          if (pick < 7) code = CH_NUL;
          else if (pick < 18) code = CH_NEWLINE;
          else if (pick < 24) code = CH_CR;
          else if (pick < 36) code = CH_TAB;
          else code = pick_printable();
        end
        send_item(is_reset, code);
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_after_reset();
    test_control_chars();
    test_one_cell_screen();
    test_far_corner();
    test_cursor_clamp();
    test_random_text();
    drain_results();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== text_cursor_display_commands_top.f =====
sv/tcd_pkg.sv
sv/tcd_front.sv
sv/tcd_queue.sv
sv/tcd_back.sv
sv/text_cursor_display_commands_top.sv
sv/tcd_checker.sv
tb/tb_top.sv
